FILE: sv/ihm_pkg.sv
// ----------------------------------------------------------------------------
// ihm_pkg
// Shared types and codes of the insertion-ordered hash map unit.
// ----------------------------------------------------------------------------
package ihm_pkg;

    // Operation codes carried in the mode field.
    typedef enum logic [2:0] {
        MODE_PUT  = 3'd0,
        MODE_DEL  = 3'd1,
        MODE_GET  = 3'd2,
        MODE_PREV = 3'd3,
        MODE_NEXT = 3'd4
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_BREAD,
        S_BHEAD,
        S_EREAD,
        S_ECHK,
        S_EXEC,
        S_NB_RD,
        S_NB_WT,
        S_ALLOC_RD,
        S_ALLOC_WT,
        S_INSERT,
        S_NXT_RD,
        S_NXT_WR,
        S_PRV_RD,
        S_PRV_WR,
        S_CHN_RD,
        S_CHN_WR,
        S_RESP
    } state_t;

    // Request transaction payload.
    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] key;
        logic [63:0] value;
    } in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] value_out;
    } out_t;

endpackage

FILE: sv/ihm_ram.sv
// ----------------------------------------------------------------------------
// ihm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ihm_ram #(
    parameter int W = 8,
    parameter int D = 2,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/ihm_hash.sv
// ----------------------------------------------------------------------------
// ihm_hash
// Bucket hash: folds the 64-bit key by XOR into the bucket index width and
// brings the result into the bucket range with one compare and subtract.
// ----------------------------------------------------------------------------
module ihm_hash #(
    parameter int BUCKETS = 64,
    parameter int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic [63:0]   key,
    output logic [BW-1:0] bucket
);

    logic [BW-1:0] fold;

    // XOR fold of the key bits.
    always_comb
    begin
        fold = '0;
        for (int i = 0; i < 64; i++)
        begin
            fold[i % BW] = fold[i % BW] ^ key[i];
        end
    end

    // The fold is below twice the bucket count.
    always_comb
    begin
        if ({1'b0, fold} >= (BW + 1)'(BUCKETS))
        begin
            bucket = BW'({1'b0, fold} - (BW + 1)'(BUCKETS));
        end
        else
        begin
            bucket = fold;
        end
    end

endmodule

FILE: sv/insertion_ordered_hash_map_unit.sv
// ----------------------------------------------------------------------------
// insertion_ordered_hash_map_unit
// Hash map over 64-bit keys and values that keeps insertion order as a
// doubly linked list; entries, bucket heads and the free stack sit in RAMs.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_data  (mode, key, value)
//  out     | output    | out_valid / out_ready | out_data (status, value_out)
//
// One transaction at a time: the bucket head is read, then the chain is walked
// with a read and a key compare per entry visited, then the operation runs and
// the result is formed; each change to the links of an existing entry is a read
// and a write of the entry RAM.
// After reset the bucket heads are swept empty, one per cycle, while in_ready
// stays low.
// A finished result waits in the output register; the next request is taken
// meanwhile and stalls only when its own result is ready.
// ----------------------------------------------------------------------------
module insertion_ordered_hash_map_unit #(
    parameter int ENTRIES = 256,
    parameter int BUCKETS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ihm_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ihm_pkg::out_t out_data
);

    import ihm_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int LW = AW + 1;
    localparam int CW = AW + 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int EW = 128 + 3 * LW;
    localparam logic [LW-1:0] NIL = {1'b1, {AW{1'b0}}};

    typedef struct packed {
        logic [63:0]   key;
        logic [63:0]   value;
        logic [LW-1:0] prev;
        logic [LW-1:0] next;
        logic [LW-1:0] chain;
    } entry_t;

    state_t        state_reg, state_next;
    in_t           req_reg;
    logic [BW-1:0] bkt_reg, clr_reg;
    logic [LW-1:0] cur_reg, pred_reg, head_reg, tail_reg, nb_reg;
    logic [LW-1:0] nxt_addr_reg, nxt_val_reg;
    logic [AW-1:0] e_reg, new_reg;
    logic [CW-1:0] fcnt_reg, hwm_reg;
    logic          found_reg;
    entry_t        ent_reg;
    out_t          res_reg;
    logic          out_valid_reg;
    out_t          out_data_reg;

    logic [BW-1:0] in_bkt;
    logic          e_we, e_re, b_we, b_re, s_we, s_re;
    logic [AW-1:0] e_waddr, e_raddr, s_waddr, s_raddr;
    logic [BW-1:0] b_waddr;
    logic [LW-1:0] b_wdata, b_rdata;
    logic [AW-1:0] s_wdata, s_rdata;
    entry_t        e_wdata, e_rd;
    logic [EW-1:0] e_rdata;
    logic          full, key_hit, resp_go;
    logic [LW-1:0] nb_sel;

    // Bucket hash of the incoming key.
    ihm_hash #(.BUCKETS(BUCKETS), .BW(BW)) u_hash (
        .key    (in_data.key),
        .bucket (in_bkt)
    );

    // Entry RAM: key, value, order links and chain link of every slot.
    ihm_ram #(.W(EW), .D(ENTRIES), .AW(AW)) u_entry_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .re    (e_re),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    // Bucket head RAM.
    ihm_ram #(.W(LW), .D(BUCKETS), .AW(BW)) u_bucket_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (b_re),
        .raddr (bkt_reg),
        .rdata (b_rdata)
    );

    // Stack of released slots; never-used slots come from the high-water count.
    ihm_ram #(.W(AW), .D(ENTRIES), .AW(AW)) u_free_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign e_rd    = e_rdata;
    assign full    = (fcnt_reg == '0) && (hwm_reg == CW'(ENTRIES));
    assign key_hit = (e_rd.key == req_reg.key);
    assign resp_go = !out_valid_reg || out_ready;
    assign nb_sel  = (req_reg.mode == MODE_PREV) ? ent_reg.prev : ent_reg.next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == BW'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_BREAD;
                end
            end
            S_BREAD: state_next = S_BHEAD;
            S_BHEAD: state_next = S_EREAD;
            S_EREAD: state_next = cur_reg[AW] ? S_EXEC : S_ECHK;
            S_ECHK:  state_next = key_hit ? S_EXEC : S_EREAD;
            S_EXEC:
            begin
                priority case (1'b1)
                    (req_reg.mode == MODE_PUT) && !found_reg && !full:
                        state_next = (fcnt_reg != '0) ? S_ALLOC_RD : S_INSERT;
                    (req_reg.mode == MODE_DEL) && found_reg:
                        state_next = S_NXT_RD;
                    ((req_reg.mode == MODE_PREV) || (req_reg.mode == MODE_NEXT))
                        && found_reg && !nb_sel[AW]:
                        state_next = S_NB_RD;
                    default:
                        state_next = S_RESP;
                endcase
            end
            S_NB_RD:    state_next = S_NB_WT;
            S_NB_WT:    state_next = S_RESP;
            S_ALLOC_RD: state_next = S_ALLOC_WT;
            S_ALLOC_WT: state_next = S_INSERT;
            S_INSERT:   state_next = S_NXT_RD;
            S_NXT_RD:
            begin
                if (!nxt_addr_reg[AW])
                begin
                    state_next = S_NXT_WR;
                end
                else
                begin
                    state_next = (req_reg.mode == MODE_DEL) ? S_PRV_RD : S_RESP;
                end
            end
            S_NXT_WR: state_next = (req_reg.mode == MODE_DEL) ? S_PRV_RD : S_RESP;
            S_PRV_RD: state_next = ent_reg.next[AW] ? S_CHN_RD : S_PRV_WR;
            S_PRV_WR: state_next = S_CHN_RD;
            S_CHN_RD: state_next = pred_reg[AW] ? S_RESP : S_CHN_WR;
            S_CHN_WR: state_next = S_RESP;
            S_RESP:
            begin
                if (resp_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Memory controls.
    always_comb
    begin
        e_we    = 1'b0;
        e_re    = 1'b0;
        e_waddr = e_reg;
        e_raddr = cur_reg[AW-1:0];
        e_wdata = e_rd;
        b_we    = 1'b0;
        b_re    = 1'b0;
        b_waddr = bkt_reg;
        b_wdata = NIL;
        s_we    = 1'b0;
        s_re    = 1'b0;
        s_waddr = fcnt_reg[AW-1:0];
        s_wdata = e_reg;
        s_raddr = AW'(fcnt_reg - 1'b1);
        unique case (state_reg)
            S_CLEAR:
            begin
                b_we    = 1'b1;
                b_waddr = clr_reg;
            end
            S_BREAD: b_re = 1'b1;
            S_EREAD: e_re = !cur_reg[AW];
            S_EXEC:
            begin
                if ((req_reg.mode == MODE_PUT) && found_reg)
                begin
                    e_we          = 1'b1;
                    e_wdata       = ent_reg;
                    e_wdata.value = req_reg.value;
                end
                if ((req_reg.mode == MODE_DEL) && found_reg)
                begin
                    s_we = 1'b1;
                end
            end
            S_NB_RD:
            begin
                e_re    = 1'b1;
                e_raddr = nb_reg[AW-1:0];
            end
            S_ALLOC_RD: s_re = 1'b1;
            S_INSERT:
            begin
                e_we          = 1'b1;
                e_waddr       = new_reg;
                e_wdata.key   = req_reg.key;
                e_wdata.value = req_reg.value;
                e_wdata.prev  = tail_reg;
                e_wdata.next  = NIL;
                e_wdata.chain = head_reg;
                b_we          = 1'b1;
                b_wdata       = {1'b0, new_reg};
            end
            S_NXT_RD:
            begin
                e_re    = !nxt_addr_reg[AW];
                e_raddr = nxt_addr_reg[AW-1:0];
            end
            S_NXT_WR:
            begin
                e_we         = 1'b1;
                e_waddr      = nxt_addr_reg[AW-1:0];
                e_wdata.next = nxt_val_reg;
            end
            S_PRV_RD:
            begin
                e_re    = !ent_reg.next[AW];
                e_raddr = ent_reg.next[AW-1:0];
            end
            S_PRV_WR:
            begin
                e_we         = 1'b1;
                e_waddr      = ent_reg.next[AW-1:0];
                e_wdata.prev = ent_reg.prev;
            end
            S_CHN_RD:
            begin
                e_re    = !pred_reg[AW];
                e_raddr = pred_reg[AW-1:0];
                b_we    = pred_reg[AW];
                b_wdata = ent_reg.chain;
            end
            S_CHN_WR:
            begin
                e_we          = 1'b1;
                e_waddr       = pred_reg[AW-1:0];
                e_wdata.chain = ent_reg.chain;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            tail_reg      <= NIL;
            fcnt_reg      <= '0;
            hwm_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if ((state_reg == S_EXEC) && (req_reg.mode == MODE_PUT) && !found_reg
                && !full && (fcnt_reg == '0))
            begin
                hwm_reg <= hwm_reg + 1'b1;
            end
            if ((state_reg == S_EXEC) && (req_reg.mode == MODE_DEL) && found_reg)
            begin
                fcnt_reg <= fcnt_reg + 1'b1;
                if (tail_reg == {1'b0, e_reg})
                begin
                    tail_reg <= ent_reg.prev;
                end
            end
            if (state_reg == S_ALLOC_WT)
            begin
                fcnt_reg <= fcnt_reg - 1'b1;
            end
            if (state_reg == S_INSERT)
            begin
                tail_reg <= {1'b0, new_reg};
            end
            if ((state_reg == S_RESP) && resp_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                req_reg <= in_data;
                bkt_reg <= in_bkt;
            end
            S_BHEAD:
            begin
                cur_reg  <= b_rdata;
                head_reg <= b_rdata;
                pred_reg <= NIL;
            end
            S_EREAD:
            begin
                if (cur_reg[AW])
                begin
                    found_reg <= 1'b0;
                end
            end
            S_ECHK:
            begin
                if (key_hit)
                begin
                    found_reg <= 1'b1;
                    ent_reg   <= e_rd;
                    e_reg     <= cur_reg[AW-1:0];
                end
                else
                begin
                    pred_reg <= cur_reg;
                    cur_reg  <= e_rd.chain;
                end
            end
            S_EXEC:
            begin
                nb_reg       <= nb_sel;
                nxt_addr_reg <= ent_reg.prev;
                nxt_val_reg  <= ent_reg.next;
                new_reg      <= hwm_reg[AW-1:0];
                if (req_reg.mode == MODE_PUT)
                begin
                    res_reg.status    <= (!found_reg && full) ? ST_FULL : ST_OK;
                    res_reg.value_out <= '0;
                end
                else if ((req_reg.mode == MODE_GET) && found_reg)
                begin
                    res_reg.status    <= ST_OK;
                    res_reg.value_out <= ent_reg.value;
                end
                else if ((req_reg.mode == MODE_DEL) && found_reg)
                begin
                    res_reg.status    <= ST_OK;
                    res_reg.value_out <= '0;
                end
                else
                begin
                    res_reg.status    <= ST_NONE;
                    res_reg.value_out <= '0;
                end
            end
            S_NB_WT:
            begin
                res_reg.status    <= ST_OK;
                res_reg.value_out <= e_rd.value;
            end
            S_ALLOC_WT: new_reg <= s_rdata;
            S_INSERT:
            begin
                nxt_addr_reg <= tail_reg;
                nxt_val_reg  <= {1'b0, new_reg};
            end
            S_RESP:
            begin
                if (resp_go)
                begin
                    out_data_reg <= res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    // The free stack never holds more slots than were ever handed out.
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= hwm_reg)
        else $error("free stack exceeds allocated slots");

    // An empty store has no tail.
    a_empty_tail: assert property (@(posedge clk) disable iff (!rst_n)
        ((hwm_reg == fcnt_reg) && (state_reg == S_IDLE)) |-> tail_reg[AW])
        else $error("tail set on an empty store");

    // A stalled result is held unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("result dropped or changed while stalled");

    // No request is taken during the bucket sweep.
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("request accepted during bucket sweep");
`endif

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the insertion-ordered hash map unit. Operations
// are driven through the request channel; a behavioral map predicts each
// result, which the monitor compares against the DUT output.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ihm_pkg::*;

    localparam int ENTRIES   = 256;
    localparam int BUCKETS   = 64;
    localparam int NIL       = ENTRIES;
    localparam int MAX_CYCLE = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    insertion_ordered_hash_map_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Clock generation.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Shadow map state.
    logic [63:0] map_key   [ENTRIES];
    logic [63:0] map_val   [ENTRIES];
    bit          map_used  [ENTRIES];
    int          map_prev  [ENTRIES];
    int          map_next  [ENTRIES];
    int          map_chain [ENTRIES];
    int          map_head  [BUCKETS];
    int          map_tail;
    int          free_slots[ENTRIES];
    int          free_cnt;

    in_t  pending_ops[$];
    out_t expected_results[$];
    logic [63:0] live_keys[$];

    int  err_count;
    int  cycle_count;
    int  results_seen;
    bit  idle_enable;
    int  n_full;
    int  n_found;

    function automatic int bucket_index(logic [63:0] k);
        logic [63:0] h;
        h = k * 64'h9E3779B97F4A7C15;
        return int'((h >> 32) % BUCKETS);
    endfunction

    function automatic int find_slot(logic [63:0] k);
        int e;
        int steps;
        e = map_head[bucket_index(k)];
        steps = 0;
        while (e < NIL && steps < ENTRIES)
        begin
            if (map_used[e] && map_key[e] == k)
                return e;
            e = map_chain[e];
            steps++;
        end
        return NIL;
    endfunction

    // Apply one operation to the shadow map and return the expected result.
    function automatic out_t apply_map_op(in_t op);
        out_t r;
        int   e;
        int   b;
        int   p;
        int   n;
        int   cur;
        int   nb;
        r.status    = ST_NONE;
        r.value_out = '0;
        e = find_slot(op.key);
        case (op.mode)
            MODE_PUT:
            begin
                if (e < NIL)
                begin
                    map_val[e] = op.value;
                    r.status = ST_OK;
                end
                else if (free_cnt == 0)
                    r.status = ST_FULL;
                else
                begin
                    b = bucket_index(op.key);
                    free_cnt--;
                    e = free_slots[free_cnt];
                    map_key[e]   = op.key;
                    map_val[e]   = op.value;
                    map_used[e]  = 1'b1;
                    map_chain[e] = map_head[b];
                    map_head[b]  = e;
                    map_prev[e]  = map_tail;
                    map_next[e]  = NIL;
                    if (map_tail < NIL)
                        map_next[map_tail] = e;
                    map_tail = e;
                    r.status = ST_OK;
                end
            end
            MODE_DEL:
            begin
                if (e < NIL)
                begin
                    p = map_prev[e];
                    n = map_next[e];
                    if (p < NIL)
                        map_next[p] = n;
                    if (n < NIL)
                        map_prev[n] = p;
                    if (map_tail == e)
                        map_tail = p;
                    b = bucket_index(map_key[e]);
                    if (map_head[b] == e)
                        map_head[b] = map_chain[e];
                    else
                    begin
                        cur = map_head[b];
                        while (cur < NIL)
                        begin
                            if (map_chain[cur] == e)
                            begin
                                map_chain[cur] = map_chain[e];
                                break;
                            end
                            cur = map_chain[cur];
                        end
                    end
                    map_used[e] = 1'b0;
                    free_slots[free_cnt] = e;
                    free_cnt++;
                    r.status = ST_OK;
                end
            end
            MODE_GET:
            begin
                if (e < NIL)
                begin
                    r.value_out = map_val[e];
                    r.status = ST_OK;
                end
            end
            MODE_PREV, MODE_NEXT:
            begin
                if (e < NIL)
                begin
                    nb = (op.mode == MODE_PREV) ? map_prev[e] : map_next[e];
                    if (nb < NIL)
                    begin
                        r.value_out = map_val[nb];
                        r.status = ST_OK;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        err_count++;
    endtask

    function automatic in_t make_op(logic [2:0] m, logic [63:0] k, logic [63:0] v);
        in_t op;
        op.mode  = m;
        op.key   = k;
        op.value = v;
        return op;
    endfunction

    // Pick a key: mostly likely-present ones, else edge keys or fresh random ones.
    function automatic logic [63:0] pick_key();
        if (live_keys.size() > 0 && $urandom_range(0, 99) < 75)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        if ($urandom_range(0, 9) == 0)
            return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, 24'h0,
                    8'($urandom_range(0, 15))};
        return {$urandom, $urandom};
    endfunction

    // Driver: present queued transactions.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_ops.size() > 0 &&
                (!idle_enable || $urandom_range(0, 99) >= 35))
            begin
                in_valid <= 1'b1;
                in_data  <= pending_ops.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Predict at acceptance.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            expected_results.push_back(apply_map_op(in_data));
    end

    // Monitor: check results and randomize back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", out_data.value_out, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.status != want.status)
                        report_mismatch("status", 64'(out_data.status), 64'(want.status));
                    if (out_data.value_out != want.value_out)
                        report_mismatch("value_out", out_data.value_out, want.value_out);
                    if (want.status == ST_FULL)
                        n_full++;
                    if (want.status == ST_OK)
                        n_found++;
                end
            end
            out_ready <= !idle_enable || ($urandom_range(0, 99) >= 35);
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    // Stimulus.
    initial
    begin
        logic [63:0] k;
        logic [63:0] v;
        logic [2:0]  m;
        int          r;
        err_count = 0;
        cycle_count = 0;
        results_seen = 0;
        n_full = 0;
        n_found = 0;
        idle_enable = 1'b1;
        for (int i = 0; i < BUCKETS; i++)
            map_head[i] = NIL;
        for (int i = 0; i < ENTRIES; i++)
        begin
            free_slots[i] = ENTRIES - 1 - i;
            map_used[i] = 1'b0;
        end
        free_cnt = ENTRIES;
        map_tail = NIL;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty-map lookups, extremes, neighbors, deletes, bad modes.
        pending_ops.push_back(make_op(MODE_GET, '0, '0));
        pending_ops.push_back(make_op(MODE_DEL, '1, '0));
        pending_ops.push_back(make_op(MODE_PREV, '0, '0));
        pending_ops.push_back(make_op(MODE_PUT, '0, '1));
        pending_ops.push_back(make_op(MODE_PUT, '1, '0));
        pending_ops.push_back(make_op(MODE_PUT, 64'h5555_AAAA_5555_AAAA, 64'hA5A5));
        pending_ops.push_back(make_op(MODE_PREV, '0, '0));
        pending_ops.push_back(make_op(MODE_NEXT, 64'h5555_AAAA_5555_AAAA, '0));
        pending_ops.push_back(make_op(MODE_NEXT, '0, '0));
        pending_ops.push_back(make_op(MODE_PREV, '1, '0));
        pending_ops.push_back(make_op(MODE_PUT, '1, 64'h1234));
        pending_ops.push_back(make_op(MODE_GET, '1, '0));
        pending_ops.push_back(make_op(MODE_DEL, '1, '0));
        pending_ops.push_back(make_op(MODE_NEXT, '0, '0));
        pending_ops.push_back(make_op(MODE_DEL, 64'h5555_AAAA_5555_AAAA, '0));
        pending_ops.push_back(make_op(MODE_PREV, 64'h5555_AAAA_5555_AAAA, '0));
        pending_ops.push_back(make_op(MODE_DEL, '1, '0));
        pending_ops.push_back(make_op(3'd5, '0, '1));
        pending_ops.push_back(make_op(3'd6, '0, '0));
        pending_ops.push_back(make_op(3'd7, '1, '1));
        pending_ops.push_back(make_op(MODE_DEL, '0, '0));
        wait_drained();

        // Fill the store past capacity to reach the full status, then
        // update present keys and drain part of it again.
        for (int i = 0; i < ENTRIES + 4; i++)
        begin
            k = {$urandom, $urandom};
            live_keys.push_back(k);
            pending_ops.push_back(make_op(MODE_PUT, k, {$urandom, $urandom}));
        end
        pending_ops.push_back(make_op(MODE_PUT, live_keys[3], '1));
        pending_ops.push_back(make_op(MODE_GET, live_keys[3], '0));
        // Hold off until every result is back.
        wait_drained();
        idle_enable = 1'b0;
        for (int i = 0; i < 200; i++)
        begin
            r = $urandom_range(0, live_keys.size() - 1);
            pending_ops.push_back(make_op(MODE_DEL, live_keys[r], '0));
            live_keys.delete(r);
        end
        wait_drained();
        idle_enable = 1'b1;

        // Random mixed traffic.
        for (int i = 0; i < 270; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                m = MODE_PUT;
            else if (r < 55)
                m = MODE_DEL;
            else if (r < 70)
                m = MODE_GET;
            else if (r < 84)
                m = MODE_PREV;
            else if (r < 98)
                m = MODE_NEXT;
            else
                m = 3'($urandom_range(5, 7));
            k = pick_key();
            v = {$urandom, $urandom};
            if (m == MODE_PUT)
                live_keys.push_back(k);
            if (live_keys.size() > 400)
                live_keys.delete(0);
            pending_ops.push_back(make_op(m, k, v));
            if (i == 150)
                wait_drained();
        end
        wait_drained();
        repeat (40) @(posedge clk);

        $display("covered %0d results: %0d ok, %0d full-store rejects", results_seen,
                 n_found, n_full);
        if (err_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
